[rtl/core/assert_macros.svh]
// Assertion helper macros for the marquee block checkers.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while in reset
`define CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the marquee text scroller.
// No dependencies; used by the core, the modulo unit and the checker.
package mts_pkg;

	// Operation codes of an input word
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TICK   = 2'd2,
		OP_RENDER = 2'd3
	} op_t;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd3;

	// Reset values of the registers
	localparam logic [5:0]  WINDOW_RST = 6'd18;
	localparam logic [3:0]  GAP_RST    = 4'd6;
	localparam logic [15:0] PERIOD_RST = 16'd150;
	localparam logic [15:0] PAUSE_RST  = 16'd2000;

	localparam logic [7:0]  SPACE_CHAR  = 8'h20;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_MOD    = 3'b010,
		ST_RENDER = 3'b100
	} state_t;

	// Status of the modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

[rtl/core/marquee_text_scroller_unit.sv]
`timescale 1ns / 1ps
// Marquee text scroller: text store, scroll timing and window render.
// Depends on mts_pkg, mts_ram and mts_mod_unit.
//
//   channel | signals                        | moves
//   --------+--------------------------------+------------------------------
//   in      | in_valid in_ready op char_in   | one operation word
//   out     | out_valid out_ready out_char   | one window cell per word
//           | out_last                       |
//   cfg     | cfg_we cfg_idx cfg_data        | register write, no wait
//
// Clear, append and a tick that does not step finish in idle, so ready stays high.
// A stepping tick waits in the modulo state for the bit-serial modulo unit.
// A render first runs the modulo unit unless the text fits; cells leave one per
// cycle while the output is not stalled, from the text RAM through one read stage.
// Reset (arst_n low) restores the registers and empties the text, no sweep.
// A stalled output holds the read stage; ready drops while a job is running.
module marquee_text_scroller_unit #(
	parameter int MAX_TEXT   = 64,
	parameter int MAX_WINDOW = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic [7:0]                       char_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_char,
	output logic                             out_last,
	input  logic                             cfg_we,
	input  logic [mts_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int AW    = $clog2(MAX_TEXT);
	localparam int LEN_W = $clog2(MAX_TEXT + 1);
	localparam int IDX_W = $clog2(MAX_TEXT + MAX_WINDOW + 16);

	mts_pkg::state_t    state_q;
	mts_pkg::mod_stat_t mod_stat;

	logic [5:0]       window_q;
	logic [3:0]       gap_q;
	logic [15:0]      period_q;
	logic [15:0]      pause_q;
	logic [LEN_W-1:0] len_q;
	logic [IDX_W-1:0] pos_q;
	logic [15:0]      elapsed_q;
	logic             render_q;
	logic             fit_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;

	logic             valid_s1;
	logic             space_s1;
	logic             last_s1;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	logic [6:0]       win_raw;
	logic [6:0]       win_clamp;
	logic [IDX_W-1:0] win;
	logic [IDX_W-1:0] len_x;
	logic [IDX_W-1:0] total;
	logic             fits;
	logic             accept;
	logic [15:0]      elapsed_inc;
	logic [15:0]      need;
	logic             step;
	logic             wr_en;
	logic             mod_start;
	logic [IDX_W-1:0] mod_dvd;
	logic [IDX_W-1:0] mod_res;
	logic             s1_take;
	logic             issue;
	logic             cell_space;
	logic             cell_last;
	logic             rd_en;
	logic [IDX_W-1:0] idx_inc;
	logic [IDX_W-1:0] idx_next;
	logic [7:0]       rd_data;

	// effective window: 0 acts as 1, clamp to MAX_WINDOW
	assign win_raw   = {1'b0, window_q};
	assign win_clamp = (window_q == 6'd0) ? 7'd1 :
	                   (win_raw > 7'(MAX_WINDOW)) ? 7'(MAX_WINDOW) : win_raw;
	assign win       = IDX_W'(win_clamp);

	assign len_x = IDX_W'(len_q);
	assign total = len_x + IDX_W'(gap_q);
	assign fits  = len_x <= win;

	assign in_ready = (state_q == mts_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;

	// tick timing
	assign elapsed_inc = (elapsed_q == mts_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
	assign need        = (pos_q == '0) ? pause_q : period_q;
	assign step        = elapsed_inc >= need;

	// append into the text RAM
	assign wr_en = accept && (op == mts_pkg::OP_APPEND) && (len_q < LEN_W'(MAX_TEXT));

	// modulo job: position for a render, position + 1 for a step
	assign mod_start = accept && !fits &&
	                   (((op == mts_pkg::OP_TICK) && step) || (op == mts_pkg::OP_RENDER));
	assign mod_dvd   = (op == mts_pkg::OP_RENDER) ? pos_q : pos_q + 1'b1;

	// render: one cell enters the read stage when that stage can move on
	assign s1_take    = valid_s1 && (!out_valid_q || out_ready);
	assign issue      = (state_q == mts_pkg::ST_RENDER) && (!valid_s1 || s1_take);
	assign cell_space = len_x <= idx_q;
	assign cell_last  = (cnt_q + 1'b1) == win;
	assign rd_en      = issue && !cell_space;
	assign idx_inc    = idx_q + 1'b1;
	assign idx_next   = (!fit_q && (idx_inc == total)) ? '0 : idx_inc;

	mts_ram #(
		.WIDTH (8),
		.DEPTH (MAX_TEXT)
	) u_text_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (len_q[AW-1:0]),
		.wdata (char_in),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	mts_mod_unit #(
		.W (IDX_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (total),
		.stat     (mod_stat),
		.result   (mod_res)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= mts_pkg::WINDOW_RST;
			gap_q    <= mts_pkg::GAP_RST;
			period_q <= mts_pkg::PERIOD_RST;
			pause_q  <= mts_pkg::PAUSE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				mts_pkg::CFG_WINDOW: window_q <= cfg_data[5:0];
				mts_pkg::CFG_GAP:    gap_q    <= cfg_data[3:0];
				mts_pkg::CFG_PERIOD: period_q <= cfg_data;
				mts_pkg::CFG_PAUSE:  pause_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mts_pkg::ST_IDLE;
			len_q     <= '0;
			pos_q     <= '0;
			elapsed_q <= '0;
			render_q  <= 1'b0;
			fit_q     <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				mts_pkg::ST_IDLE: begin
					if (accept) begin
						case (op)
							mts_pkg::OP_CLEAR: begin
								len_q     <= '0;
								pos_q     <= '0;
								elapsed_q <= '0;
							end
							mts_pkg::OP_APPEND: begin
								if (wr_en) begin
									len_q <= len_q + 1'b1;
								end
							end
							mts_pkg::OP_TICK: begin
								if (fits) begin
									pos_q     <= '0;
									elapsed_q <= elapsed_inc;
								end else if (step) begin
									elapsed_q <= '0;
									render_q  <= 1'b0;
									state_q   <= mts_pkg::ST_MOD;
								end else begin
									elapsed_q <= elapsed_inc;
								end
							end
							mts_pkg::OP_RENDER: begin
								cnt_q <= '0;
								if (fits) begin
									fit_q   <= 1'b1;
									idx_q   <= '0;
									state_q <= mts_pkg::ST_RENDER;
								end else begin
									fit_q    <= 1'b0;
									render_q <= 1'b1;
									state_q  <= mts_pkg::ST_MOD;
								end
							end
							default: ;
						endcase
					end
				end
				mts_pkg::ST_MOD: begin
					if (mod_stat.done) begin
						if (render_q) begin
							idx_q   <= mod_res;
							state_q <= mts_pkg::ST_RENDER;
						end else begin
							pos_q   <= mod_res;
							state_q <= mts_pkg::ST_IDLE;
						end
					end
				end
				mts_pkg::ST_RENDER: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						idx_q <= idx_next;
						if (cell_last) begin
							state_q <= mts_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= mts_pkg::ST_IDLE;
			endcase
		end
	end

	// read stage and output register valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
			if (s1_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// read stage and output register payload
	always_ff @(posedge clk) begin
		if (issue) begin
			space_s1 <= cell_space;
			last_s1  <= cell_last;
		end
		if (s1_take) begin
			out_char_q <= space_s1 ? mts_pkg::SPACE_CHAR : rd_data;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

[rtl/core/mts_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/mts_mod_unit.sv]
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle, all W bits a job.
// Depends on mts_pkg for the status struct.
module mts_mod_unit #(
	parameter int W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [W-1:0]      dividend,
	input  logic [W-1:0]      divisor,
	output mts_pkg::mod_stat_t stat,
	output logic [W-1:0]      result
);

	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     dsr_q;
	logic [W-1:0]     rem_q;
	logic [W:0]       trial;
	logic             fits_sub;
	logic [W:0]       trial_sub;

	// partial remainder with the next dividend bit shifted in
	assign trial     = {rem_q, dvd_q[W-1]};
	assign fits_sub  = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= fits_sub ? trial_sub[W-1:0] : trial[W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = rem_q;

endmodule

[rtl/core/mts_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the marquee text scroller, bound to the top level.
// Depends on mts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mts_port_props (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] op,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	logic in_take;
	logic out_stall;

	assign in_take   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	// a stalled output word holds
	`CHK_NEXT(a_out_hold, out_stall, out_valid && $stable({out_char, out_last}), "stalled word moved")

	// a render always occupies the block for at least the next cycle
	`CHK_NEXT(a_render_busy, in_take && (op == mts_pkg::OP_RENDER), !in_ready, "render let input in")

	// clear and append leave input ready again in the next cycle
	`CHK_NEXT(a_clear_fast, in_take && (op == mts_pkg::OP_CLEAR), in_ready, "clear ran long")
	`CHK_NEXT(a_append_fast, in_take && (op == mts_pkg::OP_APPEND), in_ready, "append ran long")

endmodule

bind marquee_text_scroller_unit mts_port_props u_mts_port_props (.*);
